### rtl/plcs_pkg.sv
// shared types and constants for the piecewise linear contrast stretch
package plcs_pkg;

    localparam int PIX_W     = 8;
    localparam int MAG_W     = 2 * PIX_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_IN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_IN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_OUT = 2'd3;

    localparam logic [PIX_W-1:0] RST_FIRST_IN   = 8'd64;
    localparam logic [PIX_W-1:0] RST_FIRST_OUT  = 8'd32;
    localparam logic [PIX_W-1:0] RST_SECOND_IN  = 8'd192;
    localparam logic [PIX_W-1:0] RST_SECOND_OUT = 8'd224;

    // knot settings seen by the segment select stage
    typedef struct packed {
        logic [PIX_W-1:0] first_in;
        logic [PIX_W-1:0] first_out;
        logic [PIX_W-1:0] second_in;
        logic [PIX_W-1:0] second_out;
    } t_knots;

    // segment chosen for one pixel
    typedef struct packed {
        logic [PIX_W-1:0] offset;
        logic             neg;
        logic [PIX_W-1:0] dmag;
        logic [PIX_W-1:0] diff;
        logic [PIX_W-1:0] din;
    } t_seg;

    // divider working set: partial remainder and quotient bits
    typedef struct packed {
        logic [PIX_W-1:0] offset;
        logic             neg;
        logic [MAG_W-1:0] rem;
        logic [PIX_W-1:0] quo;
        logic [PIX_W-1:0] din;
    } t_div;

endpackage

### rtl/plcs_seg.sv
// segment select and slope multiply stages
module plcs_seg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [7:0]        i_pixel,
    input  plcs_pkg::t_knots  i_knots,
    output logic              o_vld,
    output plcs_pkg::t_div    o_data
);
    import plcs_pkg::*;

    t_seg n_a;
    t_seg r_a;
    logic r_a_vld;
    t_div n_b;
    t_div r_b;
    logic r_b_vld;

    always_comb begin
        n_a = '0;
        if (i_pixel <= i_knots.first_in) begin
            if (i_knots.first_in == '0) begin
                // knot at zero: pixel 0 lands on the first knot output
                n_a.offset = i_knots.first_out;
                n_a.din    = PIX_W'(1);
            end else begin
                n_a.dmag = i_knots.first_out;
                n_a.diff = i_pixel;
                n_a.din  = i_knots.first_in;
            end
        end else if (i_pixel <= i_knots.second_in) begin
            n_a.offset = i_knots.first_out;
            n_a.neg    = i_knots.second_out < i_knots.first_out;
            n_a.dmag   = n_a.neg ? i_knots.first_out - i_knots.second_out
                                 : i_knots.second_out - i_knots.first_out;
            n_a.diff   = i_pixel - i_knots.first_in;
            n_a.din    = i_knots.second_in - i_knots.first_in;
        end else begin
            n_a.offset = i_knots.second_out;
            n_a.dmag   = PIX_MAX - i_knots.second_out;
            n_a.diff   = i_pixel - i_knots.second_in;
            n_a.din    = PIX_MAX - i_knots.second_in;
        end
    end

    always_comb begin
        n_b        = '0;
        n_b.offset = r_a.offset;
        n_b.neg    = r_a.neg;
        n_b.rem    = MAG_W'(r_a.dmag) * MAG_W'(r_a.diff);
        n_b.din    = r_a.din;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_data = r_b;

    // the quotient must fit a pixel, so the distance never exceeds the span
    a_diff_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> (r_a.diff <= r_a.din))
        else $error("segment distance exceeds segment span");

endmodule

### rtl/plcs_div.sv
// restoring divider, one quotient bit per pipeline stage
module plcs_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  plcs_pkg::t_div  i_data,
    output logic            o_vld,
    output plcs_pkg::t_div  o_data
);
    import plcs_pkg::*;

    t_div r_st  [PIX_W];
    logic r_vld [PIX_W];

    for (genvar k = 0; k < PIX_W; k++) begin : g_step
        localparam int BIT = PIX_W - 1 - k;
        t_div             prev;
        logic             prev_vld;
        t_div             n_st;
        logic [MAG_W-1:0] sh;

        if (k == 0) begin : g_first
            assign prev     = i_data;
            assign prev_vld = i_vld;
        end else begin : g_next
            assign prev     = r_st[k-1];
            assign prev_vld = r_vld[k-1];
        end

        assign sh = MAG_W'(prev.din) << BIT;

        always_comb begin
            n_st = prev;
            if (prev.rem >= sh) begin
                n_st.rem      = prev.rem - sh;
                n_st.quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= prev_vld;
            end
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_vld  = r_vld[PIX_W-1];
    assign o_data = r_st[PIX_W-1];

    // after the last step the remainder is below the divisor
    a_rem_below_din: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIX_W-1] |-> (r_st[PIX_W-1].rem < MAG_W'(r_st[PIX_W-1].din)))
        else $error("divider remainder not reduced");

endmodule

### rtl/plcs_out.sv
// half to even rounding, offset add and clamp stages
module plcs_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  plcs_pkg::t_div  i_data,
    output logic            o_vld,
    output logic [7:0]      o_pixel
);
    import plcs_pkg::*;

    logic [PIX_W:0]   twice_rem;
    logic [PIX_W:0]   din_ext;
    logic             round_up;
    logic [PIX_W:0]   n_qr;
    logic [PIX_W:0]   r_qr;
    logic [PIX_W-1:0] r_offset;
    logic             r_neg;
    logic             r_r_vld;
    logic signed [PIX_W+2:0] sum;
    logic [PIX_W-1:0] n_pixel;
    logic [PIX_W-1:0] r_pixel;
    logic             r_f_vld;

    assign twice_rem = {i_data.rem[PIX_W-1:0], 1'b0};
    assign din_ext   = {1'b0, i_data.din};
    // ties go to the even quotient
    assign round_up  = (twice_rem > din_ext) || ((twice_rem == din_ext) && i_data.quo[0]);
    assign n_qr      = {1'b0, i_data.quo} + (PIX_W+1)'(round_up);

    always_comb begin
        if (r_neg) begin
            sum = $signed({3'b000, r_offset}) - $signed({2'b00, r_qr});
        end else begin
            sum = $signed({3'b000, r_offset}) + $signed({2'b00, r_qr});
        end
        if (sum < 0) begin
            n_pixel = '0;
        end else if (sum > $signed({3'b000, PIX_MAX})) begin
            n_pixel = PIX_MAX;
        end else begin
            n_pixel = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_r_vld <= i_vld;
            r_f_vld <= r_r_vld;
        end
        if (i_en) begin
            r_qr     <= n_qr;
            r_offset <= i_data.offset;
            r_neg    <= i_data.neg;
            r_pixel  <= n_pixel;
        end
    end

    assign o_vld   = r_f_vld;
    assign o_pixel = r_pixel;

    // a rounded quotient never passes one full pixel range
    a_qr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_vld |-> (r_qr <= (PIX_W+1)'(256)))
        else $error("rounded quotient out of range");

endmodule

### rtl/piecewise_linear_contrast_stretch.sv
// top level of the piecewise linear contrast stretch
//
//   channel   direction   handshake                      payload
//   in        to block    i_in_valid / o_in_stall        i_pixel_in
//   out       from block  o_out_valid / i_out_stall      o_pixel_out
//   cfg       to block    i_cfg_we                       i_cfg_idx, i_cfg_data
//
// one pixel per clock unless the output stalls; segment select, multiply,
// 8 divider steps (one quotient bit each), rounding, offset add and clamp
// reset clears all valid bits and loads the default knots, no clearing pass
// a stall on a valid output beat freezes every stage at once; nothing is dropped
module piecewise_linear_contrast_stretch (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_pixel_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_pixel_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import plcs_pkg::*;

    t_knots r_knots;
    logic   en;
    logic   seg_vld;
    t_div   seg_data;
    logic   div_vld;
    t_div   div_data;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knots.first_in   <= RST_FIRST_IN;
            r_knots.first_out  <= RST_FIRST_OUT;
            r_knots.second_in  <= RST_SECOND_IN;
            r_knots.second_out <= RST_SECOND_OUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_IN:   r_knots.first_in   <= i_cfg_data;
                CFG_FIRST_OUT:  r_knots.first_out  <= i_cfg_data;
                CFG_SECOND_IN:  r_knots.second_in  <= i_cfg_data;
                CFG_SECOND_OUT: r_knots.second_out <= i_cfg_data;
                default: ;
            endcase
        end
    end

    plcs_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_pixel (i_pixel_in),
        .i_knots (r_knots),
        .o_vld   (seg_vld),
        .o_data  (seg_data)
    );

    plcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (seg_vld),
        .i_data  (seg_data),
        .o_vld   (div_vld),
        .o_data  (div_data)
    );

    plcs_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (div_vld),
        .i_data  (div_data),
        .o_vld   (o_out_valid),
        .o_pixel (o_pixel_out)
    );

    // backpressure only ever comes from a held output beat
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output beat");

endmodule

### verif/tb_top.sv
// testbench for the piecewise linear contrast stretch: directed knots, ties, backpressure, random phases
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plcs_pkg::*;

    localparam int PIPE_LATENCY = 12;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_PIXELS = 145;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    logic [PIX_W-1:0] i_pixel_in  = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [PIX_W-1:0] o_pixel_out;
    logic             i_cfg_we    = 1'b0;
    logic [1:0]       i_cfg_idx   = CFG_FIRST_IN;
    logic [PIX_W-1:0] i_cfg_data  = '0;

    // local copy of the knot registers
    logic [PIX_W-1:0] kn_first_in   = RST_FIRST_IN;
    logic [PIX_W-1:0] kn_first_out  = RST_FIRST_OUT;
    logic [PIX_W-1:0] kn_second_in  = RST_SECOND_IN;
    logic [PIX_W-1:0] kn_second_out = RST_SECOND_OUT;

    logic [PIX_W-1:0] pixel_expect_q[$];
    logic [PIX_W-1:0] expected_pixel;
    int               fail_count  = 0;
    int               cycle_count = 0;
    int               in_gap_max  = 19;
    int               out_gap_max = 19;
    int               long_hold   = 0;

    piecewise_linear_contrast_stretch uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // signed quotient rounded half to even, den > 0
    function automatic int round_half_even(input int num, input int den);
        int q;
        int r;
        q = num / den;
        r = num - q * den;
        if (r < 0) begin
            q = q - 1;
            r = r + den;
        end
        if (2 * r > den || (2 * r == den && (q % 2) != 0)) begin
            q = q + 1;
        end
        return q;
    endfunction

    function automatic logic [PIX_W-1:0] stretch_pixel(input logic [PIX_W-1:0] pix);
        int p;
        int r1;
        int s1;
        int r2;
        int s2;
        int top;
        int y;
        p   = int'(pix);
        r1  = int'(kn_first_in);
        s1  = int'(kn_first_out);
        r2  = int'(kn_second_in);
        s2  = int'(kn_second_out);
        top = int'(PIX_MAX);
        if (p <= r1) begin
            y = (r1 == 0) ? s1 : round_half_even(s1 * p, r1);
        end else if (p <= r2) begin
            y = s1 + round_half_even((s2 - s1) * (p - r1), r2 - r1);
        end else begin
            y = s2 + round_half_even((top - s2) * (p - r2), top - r2);
        end
        if (y < 0) y = 0;
        if (y > top) y = top;
        return PIX_W'(y);
    endfunction

    // compare every output beat with the oldest pending pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_expect_q.size() == 0) begin
                $error("pixel_out: expected no beat, actual %0d", o_pixel_out);
                fail_count = fail_count + 1;
            end else begin
                expected_pixel = pixel_expect_q.pop_front();
                if (o_pixel_out !== expected_pixel) begin
                    $error("pixel_out: expected %0d, actual %0d", expected_pixel, o_pixel_out);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // output side: random hold-off before each beat, or one long hold when asked
    initial begin
        int wait_cycles;
        forever begin
            wait_cycles = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
            if (long_hold > 0) begin
                wait_cycles = long_hold;
                long_hold   = 0;
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (o_in_stall);
        pixel_expect_q.push_back(stretch_pixel(pix));
    endtask

    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (pixel_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [PIX_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_FIRST_IN:   kn_first_in   = val;
            CFG_FIRST_OUT:  kn_first_out  = val;
            CFG_SECOND_IN:  kn_second_in  = val;
            CFG_SECOND_OUT: kn_second_out = val;
            default: ;
        endcase
    endtask

    task automatic set_knots(input logic [PIX_W-1:0] fi, input logic [PIX_W-1:0] fo,
                             input logic [PIX_W-1:0] si, input logic [PIX_W-1:0] so);
        write_reg(CFG_FIRST_IN, fi);
        write_reg(CFG_FIRST_OUT, fo);
        write_reg(CFG_SECOND_IN, si);
        write_reg(CFG_SECOND_OUT, so);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_default_knots();
        logic [PIX_W-1:0] pixels[8];
        pixels = '{8'd0, 8'd63, 8'd64, 8'd65, 8'd192, 8'd193, 8'd254, 8'd255};
        foreach (pixels[k]) send_pixel(pixels[k]);
        settle_pipeline();
    endtask

    task automatic test_first_knot_zero();
        set_knots(8'd0, 8'd100, 8'd128, 8'd200);
        send_pixel(8'd0);
        send_pixel(8'd255);
        settle_pipeline();
    endtask

    task automatic test_knots_out_of_order();
        set_knots(8'd200, 8'd50, 8'd100, 8'd250);
        send_pixel(8'd150);
        send_pixel(8'd200);
        send_pixel(8'd201);
        settle_pipeline();
    endtask

    // exact halves on rising and falling segments
    task automatic test_rounding_ties();
        set_knots(8'd2, 8'd3, 8'd4, 8'd0);
        send_pixel(8'd1);
        send_pixel(8'd3);
        settle_pipeline();
        set_knots(8'd2, 8'd1, 8'd4, 8'd2);
        send_pixel(8'd1);
        send_pixel(8'd3);
        settle_pipeline();
    endtask

    // receiver holds off long enough for the pipe to fill and stall its input
    task automatic test_output_backpressure();
        set_knots(8'd50, 8'd10, 8'd180, 8'd240);
        in_gap_max = 0;
        long_hold  = 150;
        repeat (60) send_pixel(PIX_W'($urandom_range(0, 255)));
        settle_pipeline();
        in_gap_max = 19;
    endtask

    task automatic test_random_phases();
        logic [PIX_W-1:0] fi;
        logic [PIX_W-1:0] fo;
        logic [PIX_W-1:0] si;
        logic [PIX_W-1:0] so;
        logic [PIX_W-1:0] tmp;
        logic [PIX_W-1:0] pix;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0: begin in_gap_max = 19; out_gap_max = 19; end
                1: begin in_gap_max = 0;  out_gap_max = 19; end
                2: begin in_gap_max = 19; out_gap_max = 0;  end
                default: begin in_gap_max = 0; out_gap_max = 0; end
            endcase
            if (phase == 0) begin
                {fi, fo, si, so} = {8'd0, 8'd0, 8'd0, 8'd0};
            end else if (phase == 1) begin
                {fi, fo, si, so} = {PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX};
            end else if (phase == 2) begin
                {fi, fo, si, so} = {8'd0, PIX_MAX, PIX_MAX, 8'd0};
            end else begin
                fi = PIX_W'($urandom_range(0, 255));
                fo = PIX_W'($urandom_range(0, 255));
                si = PIX_W'($urandom_range(0, 255));
                so = PIX_W'($urandom_range(0, 255));
                // mostly ordered knots so the middle segment gets used
                if ($urandom_range(0, 3) != 0 && fi > si) begin
                    tmp = fi;
                    fi  = si;
                    si  = tmp;
                end
            end
            set_knots(fi, fo, si, so);
            repeat (PHASE_PIXELS) begin
                case ($urandom_range(0, 4))
                    0: pix = fi + PIX_W'($urandom_range(0, 2)) - 8'd1;
                    1: pix = si + PIX_W'($urandom_range(0, 2)) - 8'd1;
                    default: pix = PIX_W'($urandom_range(0, 255));
                endcase
                send_pixel(pix);
            end
            settle_pipeline();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_knots();
        test_first_knot_zero();
        test_knots_out_of_order();
        test_rounding_ties();
        test_output_backpressure();
        test_random_phases();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
